FILE: hdl/pse_pkg.sv
// shared types, sizes and codes for the postfix stack evaluator
package pse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int FRAC_BITS   = 16;
	localparam int WORD_W      = 32;
	localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int NUM_W       = WORD_W + FRAC_BITS;
	localparam int STEP_W      = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam int MAG_W       = 2 * WORD_W;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_END  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_DIVZERO   = 3'd2,
		ST_BADOP     = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_LEFTOVER  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_WAIT
	} top_state_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_SAT
	} alu_state_t;

	// shift control shared by every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

	function automatic word_t magnitude(word_t u);
		return u[WORD_W-1] ? word_t'(~u + word_t'(1)) : u;
	endfunction

endpackage

FILE: hdl/postfix_stack_evaluator.sv
// postfix evaluator top: token control, row of stack cells, shared mul/div unit
// push, add, sub, end and error tokens are handled without a wait state; end's result shows the next cycle.
// mul holds the block in T_WAIT while the shared unit registers, multiplies and saturates.
// div holds it in T_WAIT while the divider forms one quotient bit per cycle, then saturates.
// a new request is taken while a result waits, unless it is an end that would overwrite it.
// arst_n clears the count, error latch and result valid; stack cells are not reset.
module postfix_stack_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [2:0]         status
);

	pse_pkg::top_state_t state_q, state_d;
	pse_pkg::count_t     count_q, count_d;
	pse_pkg::status_t    err_q, err_d;
	logic                out_valid_q, out_valid_d;
	pse_pkg::word_t      value_q, value_d;
	pse_pkg::status_t    status_q, status_d;
	logic                out_load;

	pse_pkg::cell_ctrl_t ctrl;
	pse_pkg::word_t      cell_d [pse_pkg::STACK_DEPTH];
	pse_pkg::word_t      top_res;
	logic                alu_start, alu_div, alu_done;
	pse_pkg::word_t      alu_res;
	logic                accept;
	pse_pkg::status_t    end_status;

	assign in_stall = (state_q != pse_pkg::T_IDLE) || (out_valid_q && out_stall
	                  && opcode == pse_pkg::OP_END);
	assign accept   = in_valid && !in_stall;

	genvar gi;
	generate
		for (gi = 0; gi < pse_pkg::STACK_DEPTH; gi++) begin : g_cell
			pse_pkg::word_t above, below;
			if (gi == 0) begin : g_top
				assign above = operand;
				assign below = top_res;
			end else begin : g_mid
				assign above = cell_d[gi-1];
				if (gi == pse_pkg::STACK_DEPTH - 1) begin : g_last
					assign below = '0;
				end else begin : g_inner
					assign below = cell_d[gi+1];
				end
			end
			pse_cell u_cell (
				.clk   (clk),
				.ctrl  (ctrl),
				.above (above),
				.below (below),
				.data  (cell_d[gi])
			);
		end
	endgenerate

	pse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.is_div (alu_div),
		.left   (cell_d[1]),
		.right  (cell_d[0]),
		.done   (alu_done),
		.result (alu_res)
	);

	always_comb begin
		if (err_q != pse_pkg::ST_OK) begin
			end_status = err_q;
		end else if (count_q == '0) begin
			end_status = pse_pkg::ST_UNDERFLOW;
		end else if (count_q > pse_pkg::count_t'(1)) begin
			end_status = pse_pkg::ST_LEFTOVER;
		end else begin
			end_status = pse_pkg::ST_OK;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		err_d     = err_q;
		ctrl      = '0;
		top_res   = alu_res;
		alu_start = 1'b0;
		alu_div   = 1'b0;
		out_load  = 1'b0;
		value_d   = '0;
		status_d  = end_status;
		case (state_q)
			pse_pkg::T_IDLE: begin
				if (accept) begin
					if (opcode == pse_pkg::OP_END) begin
						out_load = 1'b1;
						if (end_status == pse_pkg::ST_OK) begin
							value_d = cell_d[0];
						end
						count_d = '0;
						err_d   = pse_pkg::ST_OK;
					end else if (err_q != pse_pkg::ST_OK) begin
						// ignore everything until end
					end else if (opcode == pse_pkg::OP_PUSH) begin
						if (count_q == pse_pkg::count_t'(pse_pkg::STACK_DEPTH)) begin
							err_d = pse_pkg::ST_OVERFLOW;
						end else begin
							ctrl.push = 1'b1;
							count_d   = count_q + pse_pkg::count_t'(1);
						end
					end else if (count_q < pse_pkg::count_t'(2)) begin
						err_d = pse_pkg::ST_UNDERFLOW;
					end else begin
						case (opcode)
							pse_pkg::OP_ADD: begin
								top_res  = cell_d[1] + cell_d[0];
								ctrl.pop = 1'b1;
								count_d  = count_q - pse_pkg::count_t'(1);
							end
							pse_pkg::OP_SUB: begin
								top_res  = cell_d[1] - cell_d[0];
								ctrl.pop = 1'b1;
								count_d  = count_q - pse_pkg::count_t'(1);
							end
							pse_pkg::OP_MUL: begin
								alu_start = 1'b1;
								state_d   = pse_pkg::T_WAIT;
							end
							pse_pkg::OP_DIV: begin
								if (cell_d[0] == '0) begin
									err_d = pse_pkg::ST_DIVZERO;
								end else begin
									alu_start = 1'b1;
									alu_div   = 1'b1;
									state_d   = pse_pkg::T_WAIT;
								end
							end
							default: err_d = pse_pkg::ST_BADOP;
						endcase
					end
				end
			end
			pse_pkg::T_WAIT: begin
				if (alu_done) begin
					ctrl.pop = 1'b1;
					count_d  = count_q - pse_pkg::count_t'(1);
					state_d  = pse_pkg::T_IDLE;
				end
			end
			default: state_d = pse_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q && out_stall;
		if (out_load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pse_pkg::T_IDLE;
			count_q     <= '0;
			err_q       <= pse_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			err_q       <= err_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q  <= value_d;
			status_q <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

endmodule

FILE: hdl/pse_cell.sv
// one stack entry: takes the entry above on push, the entry below on pop
module pse_cell (
	input  logic                clk,
	input  pse_pkg::cell_ctrl_t ctrl,
	input  pse_pkg::word_t      above,
	input  pse_pkg::word_t      below,
	output pse_pkg::word_t      data
);

	pse_pkg::word_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= above;
		end else if (ctrl.pop) begin
			data_q <= below;
		end
	end

	assign data = data_q;

endmodule

FILE: hdl/pse_alu.sv
// shared multiply / restoring divide unit with saturation, q16.16 style fixed point
module pse_alu (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           is_div,
	input  pse_pkg::word_t left,
	input  pse_pkg::word_t right,
	output logic           done,
	output pse_pkg::word_t result
);

	pse_pkg::alu_state_t state_q, state_d;

	pse_pkg::word_t               mag_a_q, mag_b_q, rem_q;
	logic                         neg_q;
	logic [pse_pkg::NUM_W-1:0]    num_q;
	logic [pse_pkg::STEP_W-1:0]   step_q;
	logic [pse_pkg::MAG_W-1:0]    mag_q;
	logic [pse_pkg::MAG_W-1:0]    prod;
	logic [pse_pkg::WORD_W:0]     trial;
	logic                         ge;
	logic [pse_pkg::NUM_W-1:0]    num_next;
	pse_pkg::word_t               rem_next;

	assign prod     = pse_pkg::MAG_W'(mag_a_q) * pse_pkg::MAG_W'(mag_b_q);
	// one quotient bit per cycle
	assign trial    = {rem_q, num_q[pse_pkg::NUM_W-1]};
	assign ge       = trial >= {1'b0, mag_b_q};
	assign rem_next = ge ? pse_pkg::WORD_W'(trial - {1'b0, mag_b_q})
	                     : pse_pkg::WORD_W'(trial);
	assign num_next = {num_q[pse_pkg::NUM_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			pse_pkg::A_IDLE: begin
				if (start) begin
					state_d = is_div ? pse_pkg::A_DIV : pse_pkg::A_MUL;
				end
			end
			pse_pkg::A_MUL: state_d = pse_pkg::A_SAT;
			pse_pkg::A_DIV: begin
				if (step_q == '0) begin
					state_d = pse_pkg::A_SAT;
				end
			end
			pse_pkg::A_SAT: begin
				done    = 1'b1;
				state_d = pse_pkg::A_IDLE;
			end
			default: state_d = pse_pkg::A_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pse_pkg::A_IDLE: begin
				if (start) begin
					mag_a_q <= pse_pkg::magnitude(left);
					mag_b_q <= pse_pkg::magnitude(right);
					neg_q   <= left[pse_pkg::WORD_W-1] ^ right[pse_pkg::WORD_W-1];
					rem_q   <= '0;
					num_q   <= pse_pkg::NUM_W'(pse_pkg::magnitude(left)) << pse_pkg::FRAC_BITS;
					step_q  <= pse_pkg::STEP_W'(pse_pkg::NUM_W - 1);
				end
			end
			pse_pkg::A_MUL: begin
				mag_q <= prod >> pse_pkg::FRAC_BITS;
			end
			pse_pkg::A_DIV: begin
				rem_q  <= rem_next;
				num_q  <= num_next;
				step_q <= step_q - pse_pkg::STEP_W'(1);
				if (step_q == '0) begin
					mag_q <= pse_pkg::MAG_W'(num_next);
				end
			end
			default: begin
			end
		endcase
	end

	// sign and saturate to the 32-bit range
	always_comb begin
		if (neg_q) begin
			if (mag_q >= pse_pkg::MAG_W'(64'h8000_0000)) begin
				result = 32'h8000_0000;
			end else begin
				result = pse_pkg::word_t'(~mag_q[pse_pkg::WORD_W-1:0] + pse_pkg::word_t'(1));
			end
		end else begin
			if (mag_q > pse_pkg::MAG_W'(64'h7FFF_FFFF)) begin
				result = 32'h7FFF_FFFF;
			end else begin
				result = mag_q[pse_pkg::WORD_W-1:0];
			end
		end
	end

endmodule

FILE: bench/postfix_stack_evaluator_tb.sv
// self-checking testbench for the postfix stack evaluator
module postfix_stack_evaluator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pse_pkg::*;

	// opcodes the block must reject as bad operators
	localparam logic [2:0] OP_BAD_6 = 3'd6;
	localparam logic [2:0] OP_BAD_7 = 3'd7;

	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 130;

	typedef struct {
		word_t   value;
		status_t status;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        opcode;
	logic signed [31:0] operand;
	logic              out_valid;
	logic              out_stall;
	logic signed [31:0] value;
	logic [2:0]        status;

	// shadow copy of the evaluator state
	word_t   shadow_stack [STACK_DEPTH];
	int      shadow_depth;
	status_t shadow_error;
	result_t results_due [$];

	int  fail_count = 0;
	int  tokens_sent = 0;
	int  cycle_count = 0;
	bit  idle_en;
	bit  stall_en;
	bit  long_hold;

	postfix_stack_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.operand   (operand),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding", $time, results_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic word_t abs_word(word_t w);
		return w[WORD_W-1] ? (~w + 32'd1) : w;
	endfunction

	// signed saturation of a magnitude to the 32-bit range
	function automatic word_t clamp_word(logic [63:0] mag, bit neg);
		if (neg) begin
			if (mag >= 64'h8000_0000)
				return 32'h8000_0000;
			return ~mag[31:0] + 32'd1;
		end
		if (mag > 64'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic word_t q_mul(word_t a, word_t b);
		logic [63:0] prod;
		prod = {32'd0, abs_word(a)} * {32'd0, abs_word(b)};
		return clamp_word(prod >> FRAC_BITS, a[WORD_W-1] ^ b[WORD_W-1]);
	endfunction

	function automatic word_t q_div(word_t a, word_t b);
		logic [63:0] num;
		logic [63:0] den;
		num = {32'd0, abs_word(a)} << FRAC_BITS;
		den = {32'd0, abs_word(b)};
		return clamp_word(num / den, a[WORD_W-1] ^ b[WORD_W-1]);
	endfunction

	function automatic void eval_token(logic [2:0] op, word_t arg);
		word_t   lhs;
		word_t   rhs;
		word_t   res;
		status_t st;
		if (op == OP_END) begin
			st = shadow_error;
			res = '0;
			if (st == ST_OK) begin
				if (shadow_depth == 0)
					st = ST_UNDERFLOW;
				else if (shadow_depth > 1)
					st = ST_LEFTOVER;
				else
					res = shadow_stack[0];
			end
			results_due.push_back('{res, st});
			shadow_depth = 0;
			shadow_error = ST_OK;
			return;
		end
		if (shadow_error != ST_OK)
			return;
		if (op == OP_PUSH) begin
			if (shadow_depth >= STACK_DEPTH)
				shadow_error = ST_OVERFLOW;
			else begin
				shadow_stack[shadow_depth] = arg;
				shadow_depth++;
			end
			return;
		end
		// underflow wins over every other operator error
		if (shadow_depth < 2) begin
			shadow_error = ST_UNDERFLOW;
			return;
		end
		rhs = shadow_stack[shadow_depth-1];
		lhs = shadow_stack[shadow_depth-2];
		case (op)
			OP_ADD: res = lhs + rhs;
			OP_SUB: res = lhs - rhs;
			OP_MUL: res = q_mul(lhs, rhs);
			OP_DIV: begin
				if (rhs == '0) begin
					shadow_error = ST_DIVZERO;
					return;
				end
				res = q_div(lhs, rhs);
			end
			default: begin
				shadow_error = ST_BADOP;
				return;
			end
		endcase
		shadow_depth--;
		shadow_stack[shadow_depth-1] = res;
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got value %h status %0d",
					$time, value, status);
				fail_count++;
			end else begin
				due = results_due.pop_front();
				if (value !== due.value) begin
					$display("%0t ns: value mismatch, expected %h, got %h",
						$time, due.value, value);
					fail_count++;
				end
				if (status !== due.status) begin
					$display("%0t ns: status mismatch, expected %0d, got %0d",
						$time, due.status, status);
					fail_count++;
				end
			end
		end
	end

	// receiver side: random stall bursts and one long hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_en && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_token(input logic [2:0] op, input word_t arg);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		operand  <= arg;
		do @(posedge clk); while (in_stall);
		eval_token(op, arg);
		tokens_sent++;
		@(negedge clk);
	endtask

	function automatic word_t rand_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return $urandom;
			default: return word_t'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
		endcase
	endfunction

	function automatic logic [2:0] pick_operator();
		case ($urandom_range(0, 3))
			0: return OP_ADD;
			1: return OP_SUB;
			2: return OP_MUL;
			default: return OP_DIV;
		endcase
	endfunction

	task automatic random_expression(input bit well_formed);
		int n_vals;
		int depth;
		int pushed;
		if (well_formed) begin
			n_vals = $urandom_range(1, 8);
			depth = 0;
			pushed = 0;
			while (pushed < n_vals || depth > 1) begin
				if (pushed < n_vals && (depth < 2 || $urandom_range(0, 1))) begin
					send_token(OP_PUSH, rand_operand());
					pushed++;
					depth++;
				end else begin
					send_token(pick_operator(), rand_operand());
					depth--;
				end
			end
		end else begin
			repeat ($urandom_range(1, 8))
				send_token(3'($urandom_range(0, 7)), rand_operand());
		end
		send_token(OP_END, rand_operand());
	endtask

	task automatic test_directed();
		// add wraps past the top of the range
		send_token(OP_PUSH, 32'h7FFF_FFFF);
		send_token(OP_PUSH, 32'h0000_0001);
		send_token(OP_ADD, '0);
		send_token(OP_END, '0);
		// mul saturates low, then sub
		send_token(OP_PUSH, 32'h8000_0000);
		send_token(OP_PUSH, 32'h7FFF_FFFF);
		send_token(OP_MUL, '0);
		send_token(OP_PUSH, 32'hFFFF_FFFF);
		send_token(OP_SUB, '0);
		send_token(OP_END, '0);
		// divide by zero, then a push that must be ignored
		send_token(OP_PUSH, 32'h0001_0000);
		send_token(OP_PUSH, '0);
		send_token(OP_DIV, '0);
		send_token(OP_PUSH, 32'h0002_0000);
		send_token(OP_END, '0);
		// div saturates high
		send_token(OP_PUSH, 32'h8000_0000);
		send_token(OP_PUSH, 32'hFFFF_FFFF);
		send_token(OP_DIV, '0);
		send_token(OP_END, '0);
		// bad opcode with one entry reports underflow
		send_token(OP_PUSH, 32'h0000_0001);
		send_token(OP_BAD_6, '0);
		send_token(OP_END, '0);
		send_token(OP_PUSH, 32'h0000_0001);
		send_token(OP_PUSH, 32'h0000_0002);
		send_token(OP_BAD_7, '0);
		send_token(OP_END, '0);
		// leftover operands, then an empty end
		send_token(OP_PUSH, 32'hFFFF_FFFF);
		send_token(OP_PUSH, 32'h0000_0000);
		send_token(OP_END, '0);
		send_token(OP_END, '0);
	endtask

	task automatic test_stack_depth();
		int i;
		for (i = 0; i < STACK_DEPTH; i++)
			send_token(OP_PUSH, rand_operand());
		for (i = 0; i < STACK_DEPTH - 1; i++)
			send_token(i[0] ? OP_SUB : OP_ADD, '0);
		send_token(OP_END, '0);
		// one push past full
		for (i = 0; i <= STACK_DEPTH; i++)
			send_token(OP_PUSH, rand_operand());
		send_token(OP_END, '0);
	endtask

	task automatic test_backpressure();
		long_hold = 1'b1;
		repeat (12) random_expression(1'b1);
	endtask

	task automatic test_random();
		int stop_at;
		stop_at = tokens_sent + RANDOM_ITEMS;
		while (tokens_sent < stop_at) begin
			idle_en  = $urandom_range(0, 4) != 0;
			stall_en = $urandom_range(0, 4) != 0;
			random_expression($urandom_range(0, 6) != 0);
		end
	endtask

	task automatic test_no_idle();
		idle_en  = 1'b0;
		stall_en = 1'b0;
		repeat (10) random_expression(1'b1);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_PUSH;
		operand      = '0;
		idle_en      = 1'b1;
		stall_en     = 1'b1;
		long_hold    = 1'b0;
		shadow_depth = 0;
		shadow_error = ST_OK;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_stack_depth();
		test_backpressure();
		test_random();
		test_no_idle();

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: postfix_stack_evaluator.f
hdl/pse_pkg.sv
hdl/pse_cell.sv
hdl/pse_alu.sv
hdl/postfix_stack_evaluator.sv
bench/postfix_stack_evaluator_tb.sv
